// ===== hw/rtl/button_gesture_classifier_core_assert.svh =====
// Assertion macros used by the checker file of the button gesture classifier.
`ifndef BUTTON_GESTURE_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_CORE_ASSERT_SVH

// Checked at every clock edge outside of reset.
`define BGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bgc_pkg.sv =====
// Package with the types, codes and constants of the button gesture classifier.
package bgc_pkg;

  localparam int MAX_PRESSES = 15;
  localparam int TICK_W      = 32;
  localparam int TIME_IN_W   = 32;
  localparam int COUNT_W     = $clog2(MAX_PRESSES + 1);
  localparam int TIMEOUT_W   = 20;
  localparam int MARK_W      = 4;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int OP_W        = 2;
  localparam int EVENT_W     = 3;

  // Compare widths wide enough for both operands.
  localparam int MARK_CMP_W = (COUNT_W > MARK_W) ? COUNT_W : MARK_W;
  localparam int TIME_CMP_W = (TICK_W > TIMEOUT_W) ? TICK_W : TIMEOUT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_PRESSES);

  typedef enum logic [OP_W-1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_POLL    = 2'd2
  } op_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE      = 3'd0,
    EV_SHORT     = 3'd1,
    EV_MULTI_ONE = 3'd2,
    EV_MULTI_TWO = 3'd3,
    EV_LONG      = 3'd4
  } key_event_t;

  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_MULTI  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_MULTI = 2'd2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET      = TIMEOUT_W'(2000);
  localparam logic [MARK_W-1:0]    FIRST_MULTI_RESET  = MARK_W'(4);
  localparam logic [MARK_W-1:0]    SECOND_MULTI_RESET = MARK_W'(6);

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [MARK_W-1:0]    first_multi_count;
    logic [MARK_W-1:0]    second_multi_count;
  } cfg_t;

  typedef struct packed {
    logic               key_held;
    logic [COUNT_W-1:0] press_count;
    logic [TICK_W-1:0]  first_press_time;
    logic [TICK_W-1:0]  last_press_time;
  } press_state_t;

endpackage

// ===== hw/rtl/button_gesture_classifier_core.sv =====
// Top level of the button gesture classifier: input stage, press state and result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   in      | input     | in_valid / in_ready  | op, time_now
//   out     | output    | out_valid / out_ready| key_event
//   cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// One item is taken per cycle while the output is not stalled. An accepted
// item sits in the input register, where it is classified against the press
// state, until the output register can load; its result is then loaded into
// the output register. Synchronous reset empties both stages, clears the
// press state and loads the default configuration. When the output is
// stalled the result register holds, and the input register still takes one
// more item if it is empty.
module button_gesture_classifier_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bgc_pkg::OP_W-1:0]        op,
  input  logic [bgc_pkg::TIME_IN_W-1:0]   time_now,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bgc_pkg::EVENT_W-1:0]     key_event,
  input  logic                            cfg_we,
  input  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bgc_pkg::*;

  cfg_t                 cfg;
  press_state_t         seq_state;
  press_state_t         seq_state_next;
  logic                 s1_valid;
  logic [OP_W-1:0]      s1_op;
  logic [TIME_IN_W-1:0] s1_time;
  logic [TICK_W-1:0]    s1_now;
  logic [EVENT_W-1:0]   event_next;
  logic                 out_load;
  logic                 s1_advance;
  logic                 in_take;

  // The result register can load when it is empty or being drained this cycle.
  assign out_load   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_load;
  assign in_ready   = !rst && (!s1_valid || out_load);
  assign in_take    = in_valid && in_ready;

  // Event ticks are taken modulo the tick width.
  assign s1_now = TICK_W'(s1_time);

  bgc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgc_classify u_classify (
    .cfg       (cfg),
    .cur       (seq_state),
    .op        (s1_op),
    .now       (s1_now),
    .nxt       (seq_state_next),
    .key_event (event_next)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op   <= op;
      s1_time <= time_now;
    end
  end

  // Press state advances exactly once per classified item, so the next item
  // in the input register always sees the state its predecessor left.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= '0;
    end else if (s1_advance) begin
      seq_state <= seq_state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      key_event <= event_next;
    end
  end

endmodule

// ===== hw/rtl/bgc_cfg_regs.sv =====
// Configuration register file of the button gesture classifier.
module bgc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bgc_pkg::cfg_t                  cfg
);
  import bgc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks      <= TIMEOUT_RESET;
      cfg.first_multi_count  <= FIRST_MULTI_RESET;
      cfg.second_multi_count <= SECOND_MULTI_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT:      cfg.timeout_ticks      <= cfg_data[TIMEOUT_W-1:0];
        REG_FIRST_MULTI:  cfg.first_multi_count  <= cfg_data[MARK_W-1:0];
        REG_SECOND_MULTI: cfg.second_multi_count <= cfg_data[MARK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bgc_classify.sv =====
// Combinational gesture classification and press state update for one item.
module bgc_classify (
  input  bgc_pkg::cfg_t                 cfg,
  input  bgc_pkg::press_state_t         cur,
  input  logic [bgc_pkg::OP_W-1:0]      op,
  input  logic [bgc_pkg::TICK_W-1:0]    now,
  output bgc_pkg::press_state_t         nxt,
  output logic [bgc_pkg::EVENT_W-1:0]   key_event
);
  import bgc_pkg::*;

  logic [TICK_W-1:0]     first_diff;
  logic [TICK_W-1:0]     last_diff;
  logic [TIME_CMP_W-1:0] timeout_ext;
  logic [TIME_CMP_W-1:0] first_diff_ext;
  logic [TIME_CMP_W-1:0] last_diff_ext;
  logic                  in_window;
  logic                  past_first;
  logic                  past_last;
  logic [MARK_CMP_W-1:0] count_ext;
  logic [MARK_CMP_W-1:0] mark1_ext;
  logic [MARK_CMP_W-1:0] mark2_ext;
  logic                  seq_clear;
  key_event_t            ev;

  // Tick differences wrap modulo the tick width.
  assign first_diff     = now - cur.first_press_time;
  assign last_diff      = now - cur.last_press_time;
  assign timeout_ext    = TIME_CMP_W'(cfg.timeout_ticks);
  assign first_diff_ext = TIME_CMP_W'(first_diff);
  assign last_diff_ext  = TIME_CMP_W'(last_diff);
  assign in_window      = first_diff_ext < timeout_ext;
  assign past_first     = first_diff_ext > timeout_ext;
  assign past_last      = last_diff_ext > timeout_ext;

  assign count_ext = MARK_CMP_W'(cur.press_count);
  assign mark1_ext = MARK_CMP_W'(cfg.first_multi_count);
  assign mark2_ext = MARK_CMP_W'(cfg.second_multi_count);

  always_comb begin
    nxt       = cur;
    ev        = EV_NONE;
    seq_clear = 1'b0;
    case (op)
      OP_PRESS: begin
        nxt.key_held        = 1'b1;
        nxt.last_press_time = now;
        if (cur.press_count == '0) begin
          ev                   = EV_SHORT;
          nxt.first_press_time = now;
        end else if (count_ext == mark1_ext) begin
          if (in_window) ev = EV_MULTI_ONE;
        end else if (count_ext == mark2_ext) begin
          if (in_window) begin
            ev        = EV_MULTI_TWO;
            seq_clear = 1'b1;
          end
        end
        if (seq_clear) begin
          nxt.press_count      = '0;
          nxt.first_press_time = '0;
        end else if (cur.press_count < COUNT_MAX) begin
          nxt.press_count = cur.press_count + 1'b1;
        end
      end
      OP_RELEASE: begin
        nxt.key_held = 1'b0;
      end
      OP_POLL: begin
        if ((cur.press_count != '0) && past_first) begin
          if (cur.key_held) begin
            if (past_last) begin
              ev        = EV_LONG;
              seq_clear = 1'b1;
            end
          end else begin
            seq_clear = 1'b1;
          end
        end
        if (seq_clear) begin
          nxt.press_count      = '0;
          nxt.first_press_time = '0;
        end
      end
      default: ;
    endcase
  end

  assign key_event = ev;

endmodule

// ===== hw/rtl/bgc_checker.sv =====
// Port-level checker of the button gesture classifier and its bind.
`include "button_gesture_classifier_core_assert.svh"

module bgc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bgc_pkg::EVENT_W-1:0] key_event
);
  import bgc_pkg::*;

  `BGC_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(key_event),
    "stalled result changed")
  `BGC_ASSERT(a_event_range, out_valid |-> key_event <= EV_LONG, "result code out of range")
  `BGC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")
  `BGC_ASSERT(a_result_has_item,
    $rose(out_valid) |-> $past(in_valid && in_ready, 2),
    "result without an accepted item")

endmodule

bind button_gesture_classifier_core bgc_checker u_bgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .key_event (key_event)
);
